// ===== src/xorshift128_ranged_rng_top_assert.svh =====
// Assertion macros for the ranged xorshift128 generator.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef XORSHIFT128_RANGED_RNG_TOP_ASSERT_SVH
`define XORSHIFT128_RANGED_RNG_TOP_ASSERT_SVH

// Same-cycle implication.
`define XSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/xsr_pkg.sv =====
`default_nettype none

package xsr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RANGE_W   = WORD_W + 1;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // xorshift128 shift amounts
  localparam int unsigned SHIFT_A = 11;
  localparam int unsigned SHIFT_B = 19;
  localparam int unsigned SHIFT_C = 8;

  // Register reset values, also the state reset values
  localparam logic [WORD_W-1:0] RESET_SEED   = 32'd0;
  localparam logic [WORD_W-1:0] RESET_SECOND = 32'd362436069;
  localparam logic [WORD_W-1:0] RESET_THIRD  = 32'd521288629;
  localparam logic [WORD_W-1:0] RESET_FOURTH = 32'd88675123;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAW32  = 3'd0,
    ACT_RAW31  = 3'd1,
    ACT_SRANGE = 3'd2,
    ACT_URANGE = 3'd3,
    ACT_RESEED = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED   = 8'd0,
    REG_SECOND = 8'd1,
    REG_THIRD  = 8'd2,
    REG_FOURTH = 8'd3
  } cfg_reg_e;

  // Command from the request stage to the state generator
  typedef struct packed {
    logic advance;
    logic reseed;
  } step_t;

endpackage

`default_nettype wire

// ===== src/xsr_if.sv =====
`default_nettype none

// Request channel
interface xsr_req_if;
  logic                          valid;
  logic                          ready;
  logic [xsr_pkg::ACTION_W-1:0]  action;
  logic [xsr_pkg::WORD_W-1:0]    lo_bound;
  logic [xsr_pkg::WORD_W-1:0]    hi_bound;

  modport source (output valid, action, lo_bound, hi_bound, input ready);
  modport sink   (input valid, action, lo_bound, hi_bound, output ready);
endinterface

// Result channel
interface xsr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [xsr_pkg::WORD_W-1:0]  value;
  logic                        bad_range;

  modport source (output valid, value, bad_range, input ready);
  modport sink   (input valid, value, bad_range, output ready);
endinterface

// Configuration write channel
interface xsr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [xsr_pkg::CFG_IDX_W-1:0] index;
  logic [xsr_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/xsr_gen.sv =====
`default_nettype none

module xsr_gen (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  xsr_cfg_if.sink                       cfg_i,
  input  xsr_pkg::step_t                step_i,
  output logic [xsr_pkg::WORD_W-1:0]    word_o
);
  import xsr_pkg::*;

  logic [WORD_W-1:0] seed_q, second_q, third_q, fourth_q;
  logic [WORD_W-1:0] x_q, y_q, z_q, w_q;
  logic [WORD_W-1:0] t;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= RESET_SEED;
      second_q <= RESET_SECOND;
      third_q  <= RESET_THIRD;
      fourth_q <= RESET_FOURTH;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SEED:   seed_q   <= cfg_i.data;
        REG_SECOND: second_q <= cfg_i.data;
        REG_THIRD:  third_q  <= cfg_i.data;
        REG_FOURTH: fourth_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Next w of the xorshift128 step
  always_comb begin
    t      = x_q ^ (x_q << SHIFT_A);
    word_o = w_q ^ (w_q >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
  end

  // Advance or reload the state words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= RESET_SEED;
      y_q <= RESET_SECOND;
      z_q <= RESET_THIRD;
      w_q <= RESET_FOURTH;
    end else if (step_i.reseed) begin
      x_q <= seed_q;
      y_q <= second_q;
      z_q <= third_q;
      w_q <= fourth_q;
    end else if (step_i.advance) begin
      x_q <= y_q;
      y_q <= z_q;
      z_q <= w_q;
      w_q <= word_o;
    end
  end

endmodule

`default_nettype wire

// ===== src/xorshift128_ranged_rng_top.sv =====
// A request passes through 3 register stages (request, multiply, result) before its result is valid on rsp_o.
// Throughput: one request per cycle; stages stall only under output backpressure.
// Pipeline: request/state update, 32x33 multiply, final add into the result register.
// Reset (async, active low): state words and registers take their reset values,
// all pipeline stages empty.
`default_nettype none

module xorshift128_ranged_rng_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xsr_req_if.sink   req_i,
  xsr_cfg_if.sink   cfg_i,
  xsr_rsp_if.source rsp_o
);
  import xsr_pkg::*;

  `include "xorshift128_ranged_rng_top_assert.svh"

  localparam int unsigned PROD_W = WORD_W + RANGE_W;

  action_e              action;
  logic                 req_fire;
  logic                 is_range, sgn_range, bad;
  logic [WORD_W-1:0]    w_next;
  logic [RANGE_W-1:0]   range;
  logic                 ext_lo, ext_hi;
  step_t                step;

  logic                 s1_en, s2_en, out_en;

  logic                 s1_valid_q, s1_mul_q, s1_bad_q;
  logic [WORD_W-1:0]    s1_word_q, s1_word_d, s1_lo_q;
  logic [RANGE_W-1:0]   s1_range_q;

  logic [PROD_W-1:0]    product;
  logic                 s2_valid_q, s2_bad_q;
  logic [WORD_W-1:0]    s2_prod_q, s2_add_q;

  logic                 out_valid_q, out_bad_q;
  logic [WORD_W-1:0]    out_value_q;

  // Stage enables: a stage loads when empty or when its successor moves
  assign out_en      = !out_valid_q || rsp_o.ready;
  assign s2_en       = !s2_valid_q || out_en;
  assign s1_en       = !s1_valid_q || s2_en;
  assign req_i.ready = s1_en;
  assign req_fire    = req_i.valid && s1_en;

  // Decode the request, check bounds, form the range
  always_comb begin
    action    = action_e'(req_i.action);
    sgn_range = (action == ACT_SRANGE);
    is_range  = (action == ACT_SRANGE) || (action == ACT_URANGE);
    if (sgn_range) begin
      bad = $signed(req_i.lo_bound) > $signed(req_i.hi_bound);
    end else begin
      bad = is_range && (req_i.lo_bound > req_i.hi_bound);
    end
    ext_lo = sgn_range & req_i.lo_bound[WORD_W-1];
    ext_hi = sgn_range & req_i.hi_bound[WORD_W-1];
    range  = {ext_hi, req_i.hi_bound} - {ext_lo, req_i.lo_bound} + RANGE_W'(1);
  end

  // Drive the state generator
  always_comb begin
    step.reseed  = req_fire && (action == ACT_RESEED);
    step.advance = req_fire && !bad && (action == ACT_RAW32 || action == ACT_RAW31 ||
                                        is_range);
  end

  xsr_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .step_i (step),
    .word_o (w_next)
  );

  // Shape the fresh word; the signed form scales r31 by 2 to share the >>32
  always_comb begin
    unique case (action)
      ACT_RAW32:  s1_word_d = w_next;
      ACT_RAW31:  s1_word_d = {1'b0, w_next[WORD_W-2:0]};
      ACT_SRANGE: s1_word_d = bad ? '0 : {w_next[WORD_W-2:0], 1'b0};
      ACT_URANGE: s1_word_d = bad ? '0 : w_next;
      default:    s1_word_d = '0;
    endcase
  end

  // Stage 1: request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_word_q  <= s1_word_d;
      s1_lo_q    <= req_i.lo_bound;
      s1_range_q <= range;
      s1_mul_q   <= is_range && !bad;
      s1_bad_q   <= bad;
    end
  end

  // Stage 2: scale ranged requests by the range and keep the high word; other words pass through
  assign product = PROD_W'(s1_word_q) * PROD_W'(s1_range_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_prod_q <= s1_mul_q ? product[2*WORD_W-1:WORD_W] : s1_word_q;
      s2_add_q  <= s1_mul_q ? s1_lo_q : '0;
      s2_bad_q  <= s1_bad_q;
    end
  end

  // Stage 3: offset by the minimum into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_value_q <= s2_prod_q + s2_add_q;
      out_bad_q   <= s2_bad_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value     = out_value_q;
  assign rsp_o.bad_range = out_bad_q;

  // Checks
  `XSR_ASSERT_NEXT(a_bad_urange_flagged,
    req_fire && action == ACT_URANGE && req_i.lo_bound > req_i.hi_bound,
    s1_valid_q && s1_bad_q && !s1_mul_q, "unsigned bad range not flagged")
  `XSR_ASSERT_NOW(a_empty_stage_ready, !s1_valid_q, req_i.ready,
    "request refused with first stage empty")
  `XSR_ASSERT_NOW(a_bad_zero_stage2, s2_valid_q && s2_bad_q,
    s2_prod_q == '0 && s2_add_q == '0, "bad range carries nonzero data")
  `XSR_ASSERT_NOW(a_bad_zero_out, out_valid_q && out_bad_q, out_value_q == '0,
    "bad range result is not zero")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import xsr_pkg::*;

  // Action codes the block leaves undefined; they must return an empty result
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam int unsigned RANDOM_PER_PHASE = 95;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 100;
  localparam int unsigned FIRST_HOLD_AT    = 120;
  localparam int unsigned HOLD_SPACING     = 150;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   lo_bound;
    logic [WORD_W-1:0]   hi_bound;
  } rng_request_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              bad_range;
  } rng_result_t;

  logic clk;
  logic rst_n;

  xsr_req_if req_if ();
  xsr_cfg_if cfg_if ();
  xsr_rsp_if rsp_if ();

  xorshift128_ranged_rng_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  // Generator state and reseed registers as the block should hold them
  logic [WORD_W-1:0] gen_x, gen_y, gen_z, gen_w;
  logic [WORD_W-1:0] reseed_regs [4];

  rng_request_t pending_requests [$];
  rng_result_t  expected_results [$];

  int unsigned reqs_accepted;
  int unsigned results_checked;
  int unsigned range_reqs;
  int unsigned inverted_reqs;
  int unsigned reseeds_sent;
  int unsigned settings_used;
  int unsigned mismatches;

  int unsigned send_wait, send_calm;
  int unsigned recv_wait, recv_calm;
  int unsigned hold_left;
  int unsigned next_hold_at;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the xorshift128 state by one step and return the new w
  function automatic logic [WORD_W-1:0] advance_state();
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] fresh;
    t     = gen_x ^ (gen_x << SHIFT_A);
    fresh = gen_w ^ (gen_w >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
    gen_x = gen_y;
    gen_y = gen_z;
    gen_z = gen_w;
    gen_w = fresh;
    return fresh;
  endfunction

  // Work out the result of one request and update the generator state
  function automatic rng_result_t compute_rng_result(input rng_request_t r);
    rng_result_t       res;
    logic [RANGE_W-1:0] span;
    logic [WORD_W-1:0]  w;
    logic [2*WORD_W:0]  quot;
    res = '0;
    // max - min + 1 is the same bit pattern for signed and unsigned bounds
    span = {1'b0, r.hi_bound - r.lo_bound} + 1'b1;
    case (r.action)
      ACT_RAW32: begin
        res.value = advance_state();
      end
      ACT_RAW31: begin
        w = advance_state();
        res.value = {1'b0, w[WORD_W-2:0]};
      end
      ACT_SRANGE: begin
        if ($signed(r.lo_bound) > $signed(r.hi_bound)) begin
          res.bad_range = 1'b1;
        end else begin
          w = advance_state();
          quot = (65'(w[WORD_W-2:0]) * 65'(span)) >> (WORD_W - 1);
          res.value = r.lo_bound + quot[WORD_W-1:0];
        end
      end
      ACT_URANGE: begin
        if (r.lo_bound > r.hi_bound) begin
          res.bad_range = 1'b1;
        end else begin
          w = advance_state();
          quot = (65'(w) * 65'(span)) >> WORD_W;
          res.value = r.lo_bound + quot[WORD_W-1:0];
        end
      end
      ACT_RESEED: begin
        gen_x = reseed_regs[2'(REG_SEED)];
        gen_y = reseed_regs[2'(REG_SECOND)];
        gen_z = reseed_regs[2'(REG_THIRD)];
        gen_w = reseed_regs[2'(REG_FOURTH)];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Wait before the next transaction: a random draw, with runs of back-to-back traffic
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 30);
    return $urandom_range(0, 14);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_request(input logic [ACTION_W-1:0] act,
                               input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    rng_request_t r;
    r.action   = act;
    r.lo_bound = lo;
    r.hi_bound = hi;
    pending_requests.push_back(r);
  endtask

  // Mostly well-ordered ranges with random content, some inverted and some noise
  task automatic queue_random_request();
    logic [WORD_W-1:0] corners [4];
    logic [WORD_W-1:0] lo, hi;
    logic [ACTION_W-1:0] act;
    int unsigned pick;
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    pick = $urandom_range(0, 99);
    if (pick < 15)      act = ACT_RAW32;
    else if (pick < 30) act = ACT_RAW31;
    else if (pick < 60) act = ACT_SRANGE;
    else if (pick < 88) act = ACT_URANGE;
    else if (pick < 95) act = ACT_RESEED;
    else                act = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    case ($urandom_range(0, 5))
      0, 1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = $urandom;
        hi = lo + $urandom_range(0, 255);
      end
      3: begin
        lo = corners[$urandom_range(0, 3)];
        hi = corners[$urandom_range(0, 3)];
      end
      4: begin
        lo = $urandom;
        hi = lo;
      end
      default: begin
        lo = $urandom_range(0, 15) - 8;
        hi = $urandom_range(0, 15) - 8;
      end
    endcase
    // Put most range bounds in order so the generator keeps advancing
    if ($urandom_range(0, 9) != 0) begin
      if (act == ACT_SRANGE && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
      if (act == ACT_URANGE && lo > hi) {lo, hi} = {hi, lo};
    end
    queue_request(act, lo, hi);
  endtask

  // Hold until every queued request has been sent and every result has come back;
  // look after the edge has settled so a freshly popped item is seen as in flight
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_requests.size() != 0 || req_if.valid ||
               expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    reseed_regs[idx[1:0]] = data;
    cfg_if.valid <= 1'b0;
  endtask

  // Request driver: predict on each accepted transaction, then offer the next item
  always @(posedge clk) begin : drive_requests
    rng_request_t sent;
    rng_request_t upcoming;
    rng_result_t  res;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sent.action   = req_if.action;
        sent.lo_bound = req_if.lo_bound;
        sent.hi_bound = req_if.hi_bound;
        res = compute_rng_result(sent);
        expected_results.push_back(res);
        reqs_accepted <= reqs_accepted + 1;
        if (sent.action == ACT_SRANGE || sent.action == ACT_URANGE) range_reqs++;
        if (res.bad_range) inverted_reqs++;
        if (sent.action == ACT_RESEED) reseeds_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0) begin
          send_wait--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          upcoming = pending_requests.pop_front();
          req_if.valid    <= 1'b1;
          req_if.action   <= upcoming.action;
          req_if.lo_bound <= upcoming.lo_bound;
          req_if.hi_bound <= upcoming.hi_bound;
          send_wait = draw_wait(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up into the request side
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      next_hold_at <= FIRST_HOLD_AT;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (reqs_accepted >= next_hold_at) begin
      hold_left    <= LONG_HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  // Result monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    rng_result_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result value=%h bad_range=%0b",
                                  rsp_if.value, rsp_if.bad_range));
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.value !== want.value)
            note_mismatch($sformatf("value expected %h actual %h", want.value, rsp_if.value));
          if (rsp_if.bad_range !== want.bad_range)
            note_mismatch($sformatf("bad_range expected %0b actual %0b",
                                    want.bad_range, rsp_if.bad_range));
        end
        results_checked++;
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      rsp_if.ready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [WORD_W-1:0] setting [4];
    req_if.valid    = 1'b0;
    req_if.action   = ACT_RAW32;
    req_if.lo_bound = '0;
    req_if.hi_bound = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SEED;
    cfg_if.data     = '0;
    rsp_if.ready    = 1'b0;
    rst_n           = 1'b0;
    reqs_accepted   = 0;
    results_checked = 0;
    range_reqs      = 0;
    inverted_reqs   = 0;
    reseeds_sent    = 0;
    settings_used   = 1;
    mismatches      = 0;
    send_calm       = 0;
    recv_calm       = 0;
    reseed_regs[2'(REG_SEED)]   = RESET_SEED;
    reseed_regs[2'(REG_SECOND)] = RESET_SECOND;
    reseed_regs[2'(REG_THIRD)]  = RESET_THIRD;
    reseed_regs[2'(REG_FOURTH)] = RESET_FOURTH;
    gen_x = RESET_SEED;
    gen_y = RESET_SECOND;
    gen_z = RESET_THIRD;
    gen_w = RESET_FOURTH;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every action, bound extremes, inverted and full ranges
    queue_request(ACT_RAW32, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_RAW32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(ACT_RAW31, $urandom, $urandom);
    queue_request(ACT_RAW31, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(ACT_SRANGE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(ACT_SRANGE, 32'h8000_0000, 32'h8000_0000);
    queue_request(ACT_SRANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(ACT_SRANGE, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_request(ACT_SRANGE, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(ACT_SRANGE, 32'h0000_0005, 32'hFFFF_FFFD);
    queue_request(ACT_SRANGE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(ACT_URANGE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(ACT_URANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(ACT_URANGE, 32'h0000_0000, 32'h0000_0000);
    queue_request(ACT_URANGE, 32'h0000_0001, 32'h0000_0000);
    queue_request(ACT_URANGE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(ACT_URANGE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(ACT_URANGE, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(ACT_RESEED, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(ACT_RAW32, $urandom, $urandom);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      queue_request(ACTION_W'(a), $urandom, $urandom);
    queue_request(ACT_RAW32, $urandom, $urandom);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_random_request();
    wait_drained();

    // Reseed settings: alternating extremes, random, then the opposite extremes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: setting = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        1: setting = '{$urandom, $urandom, $urandom, $urandom};
        default: setting = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      endcase
      for (int r = 0; r < 4; r++) write_reg(cfg_reg_e'(r), setting[r]);
      settings_used++;
      queue_request(ACT_RESEED, $urandom, $urandom);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_random_request();
      wait_drained();
    end

    $display("Run covered %0d requests (%0d ranged, %0d inverted, %0d reseeds) over %0d settings",
             reqs_accepted, range_reqs, inverted_reqs, reseeds_sent, settings_used);
    $display("Compared %0d results, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
